### design/segment_heap_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Segment heap allocator assertion macros
// Concurrent check wrappers shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define SEGMENT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Check with the reset phase masked out.
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that also holds during reset.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Command opcodes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_ISFREE   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Placement rules.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FIT  = 1'b0;
  localparam logic CFG_HEAP = 1'b1;

  // Table update plan chosen after the scan.
  typedef enum logic [1:0] {
    PLAN_NONE  = 2'd0,
    PLAN_EXACT = 2'd1,
    PLAN_SPLIT = 2'd2,
    PLAN_MERGE = 2'd3
  } plan_t;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic scan_ev;
    logic decide;
    logic wr_a;
    logic wr_b;
    logic sh_rd;
    logic sh_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  skip_scan;
    logic  scan_done;
    plan_t plan;
    logic  sh_done;
  } sts_t;

endpackage

### design/sha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// Segment table memory, scan evaluation, table update and result registers.
// ----------------------------------------------------------------------------
`include "segment_heap_allocator_top_macros.svh"
module sha_datapath #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata,
  input  logic [1:0]    in_opcode,
  input  logic [15:0]   in_req_size,
  input  logic [15:0]   in_free_addr,
  input  sha_pkg::cmd_t cmd,
  output sha_pkg::sts_t sts,
  output logic [15:0]   out_alloc_addr,
  output logic [2:0]    out_status
);
  import sha_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int AW    = ADDR_BITS;
  localparam int CW    = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

  // Segment table.
  logic [AW-1:0] mem_start [MAX_SEGMENTS];
  logic [AW-1:0] mem_size  [MAX_SEGMENTS];
  logic          mem_free  [MAX_SEGMENTS];

  logic [1:0]       strat_r;
  logic [15:0]      heap_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] rover_r;

  logic [1:0]       op_r;
  logic [AW-1:0]    req_r;
  logic [15:0]      fa_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] base_r;

  logic [AW-1:0] rd_start_r;
  logic [AW-1:0] rd_size_r;
  logic          rd_free_r;

  logic             found_r;
  logic [IDX_W-1:0] pick_idx_r;
  logic [AW-1:0]    pick_start_r;
  logic [AW-1:0]    pick_size_r;
  logic             pick_free_r;
  logic             prev_vld_r;
  logic [AW-1:0]    prev_start_r;
  logic [AW-1:0]    prev_size_r;
  logic             prev_free_r;
  logic             grab_r;
  logic             nxt_vld_r;
  logic [AW-1:0]    nxt_size_r;
  logic             nxt_free_r;

  logic [CNT_W-1:0] wa_idx_r, wb_idx_r, sh_idx_r, cnt_new_r;
  logic [AW-1:0]    wa_start_r, wa_size_r, wb_start_r, wb_size_r;
  logic             wa_free_r, up_r;
  logic [1:0]       rm_r;
  logic [IDX_W-1:0] rov_new_r;
  logic [15:0]      res_addr_r;
  logic [2:0]       res_st_r;

  // Scan address, wrapped for next fit.
  logic [CNT_W:0]   scan_sum;
  logic [CNT_W-1:0] scan_k;
  always_comb begin
    scan_sum = {1'b0, base_r} + {1'b0, idx_r};
    if (scan_sum >= {1'b0, count_r}) begin
      scan_sum = scan_sum - {1'b0, count_r};
    end
    scan_k = scan_sum[CNT_W-1:0];
  end

  // Candidate test for the entry just read.
  logic fits, take, match;
  always_comb begin
    fits  = rd_free_r && (rd_size_r >= req_r);
    match = !found_r && (CW'(rd_start_r) == CW'(fa_r));
    case (strat_r)
      FIT_BEST:  take = fits && (!found_r || rd_size_r < pick_size_r);
      FIT_WORST: take = rd_free_r && (!found_r || rd_size_r > pick_size_r);
      default:   take = fits && !found_r;
    endcase
  end

  // Plan and new table values, chosen once the scan is complete.
  plan_t            plan;
  logic [2:0]       d_st;
  logic [15:0]      d_addr;
  logic [CNT_W-1:0] d_wa_idx, d_sh, d_cnt, i_ext, i_p1;
  logic [AW-1:0]    d_wa_start, d_wa_size, sum1;
  logic             d_wa_free, d_up, pf, nf;
  logic [1:0]       d_rm;
  logic [IDX_W-1:0] d_rov;
  always_comb begin
    i_ext      = CNT_W'(pick_idx_r);
    i_p1       = i_ext + CNT_W'(1);
    nf         = nxt_vld_r && nxt_free_r;
    pf         = prev_vld_r && prev_free_r;
    sum1       = pick_size_r + (nf ? nxt_size_r : AW'(0));
    plan       = PLAN_NONE;
    d_st       = ST_OK;
    d_addr     = 16'd0;
    d_wa_idx   = i_ext;
    d_wa_start = pick_start_r;
    d_wa_size  = pick_size_r;
    d_wa_free  = 1'b0;
    d_up       = 1'b0;
    d_rm       = 2'd0;
    d_sh       = i_ext;
    d_cnt      = count_r;
    d_rov      = rover_r;
    case (op_r)
      OP_INIT: begin
        plan       = PLAN_EXACT;
        d_wa_idx   = '0;
        d_wa_start = '0;
        d_wa_size  = AW'(heap_r);
        d_wa_free  = 1'b1;
        d_cnt      = CNT_W'(1);
        d_rov      = '0;
      end
      OP_ALLOC: begin
        if (req_r == '0 || !found_r || pick_size_r < req_r) begin
          d_st = ST_NOFIT;
        end else if (pick_size_r == req_r) begin
          plan   = PLAN_EXACT;
          d_addr = 16'(pick_start_r);
          if (strat_r == FIT_NEXT) begin
            d_rov = pick_idx_r;
          end
        end else if (count_r == MAX_CNT) begin
          d_st = ST_FULL;
        end else begin
          plan      = PLAN_SPLIT;
          d_addr    = 16'(pick_start_r);
          d_wa_size = req_r;
          d_up      = 1'b1;
          d_sh      = count_r - CNT_W'(1);
          d_cnt     = count_r + CNT_W'(1);
          if (rover_r >= pick_idx_r && CNT_W'(rover_r) < count_r) begin
            d_rov = rover_r + IDX_W'(1);
          end
          if (strat_r == FIT_NEXT) begin
            d_rov = IDX_W'(i_p1);
          end
        end
      end
      OP_FREE: begin
        if (!found_r) begin
          d_st = ST_NOTFOUND;
        end else if (pick_free_r) begin
          d_st = ST_ISFREE;
        end else begin
          plan      = PLAN_MERGE;
          d_wa_free = 1'b1;
          d_rm      = {1'b0, nf} + {1'b0, pf};
          if (nf) begin
            if (CNT_W'(d_rov) == i_p1) begin
              d_rov = pick_idx_r;
            end else if (CNT_W'(d_rov) > i_p1) begin
              d_rov = d_rov - IDX_W'(1);
            end
          end
          if (pf) begin
            d_wa_idx   = i_ext - CNT_W'(1);
            d_wa_start = prev_start_r;
            d_wa_size  = prev_size_r + sum1;
            if (d_rov >= pick_idx_r) begin
              d_rov = d_rov - IDX_W'(1);
            end
          end else begin
            d_wa_size = sum1;
          end
          d_sh  = d_wa_idx + CNT_W'(1) + CNT_W'(d_rm);
          d_cnt = count_r - CNT_W'(d_rm);
        end
      end
      default: begin
        plan = PLAN_NONE;
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts.skip_scan = !(op_r inside {OP_ALLOC, OP_FREE});
    sts.scan_done = idx_r >= count_r;
    sts.plan      = plan;
    sts.sh_done   = up_r ? (sh_idx_r <= CNT_W'(pick_idx_r)) : (sh_idx_r >= count_r);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r <= FIT_FIRST;
      heap_r  <= 16'd10000;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT) begin
        strat_r <= cfg_wdata[1:0];
      end else begin
        heap_r <= cfg_wdata;
      end
    end
  end

  // Table count and rover commit at the end of each command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rover_r <= '0;
    end else if (cmd.finish) begin
      count_r <= cnt_new_r;
      rover_r <= rov_new_r;
    end
  end

  // Command capture and scan bookkeeping. Only a next-fit allocate starts
  // at the rover; a free walks the table in address order from entry 0.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r       <= in_opcode;
      req_r      <= AW'(in_req_size);
      fa_r       <= in_free_addr;
      idx_r      <= '0;
      base_r     <= (in_opcode == OP_ALLOC && strat_r == FIT_NEXT &&
                     CNT_W'(rover_r) < count_r) ? CNT_W'(rover_r) : '0;
      found_r    <= 1'b0;
      prev_vld_r <= 1'b0;
      nxt_vld_r  <= 1'b0;
      grab_r     <= 1'b0;
    end else if (cmd.scan_ev) begin
      idx_r <= idx_r + CNT_W'(1);
      if (op_r == OP_FREE) begin
        if (match) begin
          found_r      <= 1'b1;
          pick_idx_r   <= scan_k[IDX_W-1:0];
          pick_start_r <= rd_start_r;
          pick_size_r  <= rd_size_r;
          pick_free_r  <= rd_free_r;
          grab_r       <= 1'b1;
        end else if (!found_r) begin
          prev_vld_r   <= 1'b1;
          prev_start_r <= rd_start_r;
          prev_size_r  <= rd_size_r;
          prev_free_r  <= rd_free_r;
        end
        if (grab_r) begin
          grab_r     <= 1'b0;
          nxt_vld_r  <= 1'b1;
          nxt_size_r <= rd_size_r;
          nxt_free_r <= rd_free_r;
        end
      end else if (take) begin
        found_r      <= 1'b1;
        pick_idx_r   <= scan_k[IDX_W-1:0];
        pick_start_r <= rd_start_r;
        pick_size_r  <= rd_size_r;
        pick_free_r  <= rd_free_r;
      end
    end
  end

  // Update plan registers.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      wa_idx_r   <= d_wa_idx;
      wa_start_r <= d_wa_start;
      wa_size_r  <= d_wa_size;
      wa_free_r  <= d_wa_free;
      wb_idx_r   <= i_p1;
      wb_start_r <= pick_start_r + req_r;
      wb_size_r  <= pick_size_r - req_r;
      up_r       <= d_up;
      rm_r       <= d_rm;
      sh_idx_r   <= d_sh;
      cnt_new_r  <= d_cnt;
      rov_new_r  <= d_rov;
      res_addr_r <= d_addr;
      res_st_r   <= d_st;
    end else if (cmd.sh_wr) begin
      sh_idx_r <= up_r ? sh_idx_r - CNT_W'(1) : sh_idx_r + CNT_W'(1);
    end
  end

  // Memory port selection.
  logic [IDX_W-1:0] ra, wi;
  logic             we;
  logic [AW-1:0]    wd_start, wd_size;
  logic             wd_free;
  logic [CNT_W-1:0] sh_dst;
  always_comb begin
    ra       = cmd.sh_rd ? sh_idx_r[IDX_W-1:0] : scan_k[IDX_W-1:0];
    sh_dst   = up_r ? sh_idx_r + CNT_W'(1) : sh_idx_r - CNT_W'(rm_r);
    we       = cmd.wr_a || cmd.wr_b || cmd.sh_wr;
    wi       = wa_idx_r[IDX_W-1:0];
    wd_start = wa_start_r;
    wd_size  = wa_size_r;
    wd_free  = wa_free_r;
    if (cmd.wr_b) begin
      wi       = wb_idx_r[IDX_W-1:0];
      wd_start = wb_start_r;
      wd_size  = wb_size_r;
      wd_free  = 1'b1;
    end else if (cmd.sh_wr) begin
      wi       = sh_dst[IDX_W-1:0];
      wd_start = rd_start_r;
      wd_size  = rd_size_r;
      wd_free  = rd_free_r;
    end
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[wi] <= wd_start;
      mem_size[wi]  <= wd_size;
      mem_free[wi]  <= wd_free;
    end
  end

  // Table read port with registered data.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.sh_rd) begin
      rd_start_r <= mem_start[ra];
      rd_size_r  <= mem_size[ra];
      rd_free_r  <= mem_free[ra];
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_alloc_addr <= res_addr_r;
      out_status     <= res_st_r;
    end
  end

  `SHA_ASSERT(a_count_bound, clk, rst_n, count_r <= MAX_CNT, "segment count above table depth")
  `SHA_ASSERT(a_split_room, clk, rst_n, (cmd.decide && plan == PLAN_SPLIT) |-> (count_r < MAX_CNT), "split planned on full table")

endmodule

### design/sha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// Command sequencer: scan, table update and result handoff.
// ----------------------------------------------------------------------------
`include "segment_heap_allocator_top_macros.svh"
module sha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sha_pkg::sts_t sts,
  output sha_pkg::cmd_t cmd
);
  import sha_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN_RD = 9'b000000010,
    S_SCAN_EV = 9'b000000100,
    S_DECIDE  = 9'b000001000,
    S_WR_A    = 9'b000010000,
    S_WR_B    = 9'b000100000,
    S_SH_RD   = 9'b001000000,
    S_SH_WR   = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  plan_t  plan_r, plan_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    plan_nxt  = plan_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.skip_scan || sts.scan_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        plan_nxt   = sts.plan;
        case (sts.plan)
          PLAN_SPLIT: state_nxt = S_SH_RD;
          PLAN_NONE:  state_nxt = S_RESP;
          default:    state_nxt = S_WR_A;
        endcase
      end
      S_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = (plan_r == PLAN_MERGE) ? S_SH_RD : S_RESP;
      end
      S_WR_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_WR_A;
      end
      S_SH_RD: begin
        if (sts.sh_done) begin
          state_nxt = (plan_r == PLAN_SPLIT) ? S_WR_B : S_RESP;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat valid: set on handoff, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plan_r      <= PLAN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plan_r      <= plan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SHA_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> (state_r != S_IDLE), "controller idle right after a command beat")
  `SHA_ASSERT(a_finish_valid, clk, rst_n, cmd.finish |=> out_valid_r, "result beat not presented after handoff")

endmodule

### design/segment_heap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_heap_allocator_top
// Address-ordered segment table allocator with init, allocate and free.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one command per beat (opcode, req_size,
//   free_addr). Each command yields exactly one out_ beat (alloc_addr, status).
//   One command is in progress at a time; in_stall is high while it runs.
//   Every allocate and free scans the whole table. A split shifts the entries
//   above the split point, and a successful free shifts all entries after the
//   freed block and its merged neighbors. The table's read and write ports are
//   never used in the same cycle. The next command is taken in the cycle after
//   the result is handed off.
//   A finished result sits in an output register, so a new command is taken
//   while out_stall holds the previous result; the next result then waits in
//   the controller until the output register frees up.
//   The cfg_ port is always ready; write fit_strategy (index 0) and heap_size
//   (index 1) only while no command is in flight.
//   Synchronous reset empties the table, clears the rover and loads the
//   default configuration; no clearing pass runs.
// ----------------------------------------------------------------------------
module segment_heap_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_alloc_addr,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer.
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and arithmetic.
  sha_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_opcode),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .cmd            (cmd),
    .sts            (sts),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status)
  );

endmodule
